/* rtl/assert_macros.svh */
// Assertion helpers, clocked on clock and disabled during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Condition must never hold.
`define ASSERT_NEVER(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) !(cond)) else $error(msg);

`endif

/* rtl/mlm_pkg.sv */
package mlm_pkg;

   // transaction field widths
   localparam int ACTION_W  = 3;
   localparam int CHANNEL_W = 3;
   localparam int VALUE_W   = 16;
   localparam int OVERS_W   = 16;
   localparam int COEF_W    = 16;
   localparam int ACTIVE_W  = 4;

   // configuration port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_PEAK_RELEASE   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_AVERAGE_SMOOTH = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ACTIVE_CHANS   = 2'd2;

   localparam logic [COEF_W-1:0]   PEAK_RELEASE_RST   = 16'd1000;
   localparam logic [COEF_W-1:0]   AVERAGE_SMOOTH_RST = 16'd5000;
   localparam logic [ACTIVE_W-1:0] ACTIVE_CHANS_RST   = 4'd8;

   // actions
   localparam logic [ACTION_W-1:0] ACT_PEAK        = 3'd0;
   localparam logic [ACTION_W-1:0] ACT_AVERAGE     = 3'd1;
   localparam logic [ACTION_W-1:0] ACT_ADD_OVERS   = 3'd2;
   localparam logic [ACTION_W-1:0] ACT_CLEAR_OVERS = 3'd3;
   localparam logic [ACTION_W-1:0] ACT_RESET_MAX   = 3'd4;
   localparam logic [ACTION_W-1:0] ACT_READ        = 3'd5;

   localparam logic [OVERS_W-1:0] OVER_MAX = 16'hFFFF;
   localparam int                 HALF_Q16 = 32768;

endpackage

/* rtl/mlm_ifs.sv */
interface mlm_req_if import mlm_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [ACTION_W-1:0]  action;
   logic [CHANNEL_W-1:0] channel;
   logic [VALUE_W-1:0]   sample_value;

   modport source (output valid, action, channel, sample_value, input ready);
   modport sink   (input valid, action, channel, sample_value, output ready);
endinterface

interface mlm_rsp_if import mlm_pkg::*; ();
   logic               valid;
   logic               ready;
   logic               channel_valid;
   logic [VALUE_W-1:0] peak_out;
   logic [VALUE_W-1:0] average_out;
   logic [VALUE_W-1:0] max_peak_out;
   logic [VALUE_W-1:0] max_average_out;
   logic [OVERS_W-1:0] overs_out;

   modport source (output valid, channel_valid, peak_out, average_out, max_peak_out,
                   max_average_out, overs_out, input ready);
   modport sink   (input valid, channel_valid, peak_out, average_out, max_peak_out,
                   max_average_out, overs_out, output ready);
endinterface

/* rtl/multichannel_level_meter.sv */
// Multichannel level meter with peak/average ballistics.
//
// req: one transaction = action, channel, sample_value. Peak and average
//   updates move the channel's level (instant attack / exponential release
//   for peak, exponential smoothing for average) and raise the held maxima.
//   Add-overs saturates the over count. Clear-overs and reset-maxima walk
//   every active channel. Read just returns state.
// rsp: one transaction per request, the addressed channel's state after the
//   action; a channel at or above the active count returns channel_valid=0
//   and zero fields, and is left untouched.
// csr: plain write port (csr_we/csr_index/csr_wdata); the user writes it only
//   while idle, which the block itself does not enforce.
// Flow: channel state sits in one memory, registered read. A channel action
//   runs read, multiply, write back; the next request can be taken the cycle
//   after. Clear-overs and reset-maxima read-modify-write each active channel.
// Reset clears registers and marks all memory entries empty (read as zero);
//   no clearing pass. When rsp stalls, a finished result waits in the output
//   register; the next request is still taken, its write-back waits for room.
`include "assert_macros.svh"

module multichannel_level_meter import mlm_pkg::*; #(
   parameter int NUM_CHANNELS = 8,
   parameter int LEVEL_BITS   = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   mlm_req_if.sink               req,
   mlm_rsp_if.source             rsp,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int CH_W    = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
   localparam int CNT_W   = $clog2(NUM_CHANNELS + 1);
   localparam int LIM_W   = (CNT_W > ACTIVE_W) ? CNT_W : ACTIVE_W;
   localparam int PROD_W  = COEF_W + LEVEL_BITS + 1;
   localparam int ENTRY_W = 4 * LEVEL_BITS + OVERS_W;

   // sequencer states
   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_MUL   = 3'd1;  // read data in, scale the gap
   localparam logic [2:0] ST_WB    = 3'd2;  // update, write back, respond
   localparam logic [2:0] ST_SW_RD = 3'd3;  // sweep: read entry
   localparam logic [2:0] ST_SW_WR = 3'd4;  // sweep: modify and write entry
   localparam logic [2:0] ST_RD    = 3'd5;  // read addressed channel after sweep

   typedef struct packed {
      logic [OVERS_W-1:0]    overs;
      logic [LEVEL_BITS-1:0] havg;
      logic [LEVEL_BITS-1:0] hpeak;
      logic [LEVEL_BITS-1:0] avg;
      logic [LEVEL_BITS-1:0] peak;
   } entry_type;

   // configuration
   logic [COEF_W-1:0]   rel_ff;
   logic [COEF_W-1:0]   sm_ff;
   logic [ACTIVE_W-1:0] active_ff;

   // control and captured request
   logic [2:0]           state_ff, state_in;
   logic [ACTION_W-1:0]  act_ff;
   logic [CHANNEL_W-1:0] ch_ff;
   logic [VALUE_W-1:0]   val_ff;
   logic                 ch_valid_ff;
   logic [LIM_W-1:0]     idx_ff, idx_in;
   logic [LEVEL_BITS-1:0] step_ff, step_in;
   logic                 up_ff, up_in;

   // response register
   logic                  rsp_valid_ff;
   logic                  rsp_chv_ff;
   logic [VALUE_W-1:0]    rsp_peak_ff;
   logic [VALUE_W-1:0]    rsp_avg_ff;
   logic [VALUE_W-1:0]    rsp_hpeak_ff;
   logic [VALUE_W-1:0]    rsp_havg_ff;
   logic [OVERS_W-1:0]    rsp_overs_ff;

   logic             accept;
   logic             wb_fire;
   logic [LIM_W-1:0] limit;
   logic             is_sweep;

   logic              rd_en;
   logic [CH_W-1:0]   rd_addr;
   logic [ENTRY_W-1:0] rd_data;
   logic              wr_en;
   logic [CH_W-1:0]   wr_addr;
   entry_type         cur;
   entry_type         nxt;
   entry_type         swp;

   assign accept   = req.valid && req.ready;
   assign req.ready = (state_ff == ST_IDLE);
   assign wb_fire  = (state_ff == ST_WB) && (!rsp_valid_ff || rsp.ready);
   assign cur      = entry_type'(rd_data);
   assign limit    = (LIM_W'(active_ff) > LIM_W'(NUM_CHANNELS)) ?
                     LIM_W'(NUM_CHANNELS) : LIM_W'(active_ff);
   assign is_sweep = (req.action == ACT_CLEAR_OVERS) || (req.action == ACT_RESET_MAX);

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         rel_ff    <= PEAK_RELEASE_RST;
         sm_ff     <= AVERAGE_SMOOTH_RST;
         active_ff <= ACTIVE_CHANS_RST;
      end else if (csr_we) begin
         case (csr_index)
            CSR_PEAK_RELEASE:   rel_ff    <= csr_wdata[COEF_W-1:0];
            CSR_AVERAGE_SMOOTH: sm_ff     <= csr_wdata[COEF_W-1:0];
            CSR_ACTIVE_CHANS:   active_ff <= csr_wdata[ACTIVE_W-1:0];
            default: ;
         endcase
      end
   end

   // memory port selection
   always_comb begin
      rd_en   = accept || (state_ff == ST_SW_RD) || (state_ff == ST_RD);
      rd_addr = CH_W'(req.channel);
      if (state_ff == ST_SW_RD) begin
         rd_addr = idx_ff[CH_W-1:0];
      end else if (state_ff == ST_RD) begin
         rd_addr = CH_W'(ch_ff);
      end
      wr_en   = (state_ff == ST_SW_WR) || (wb_fire && ch_valid_ff);
      wr_addr = (state_ff == ST_SW_WR) ? idx_ff[CH_W-1:0] : CH_W'(ch_ff);
   end

   // gap scaling: coef * gap, rounded, Q0.16
   always_comb begin
      logic [LEVEL_BITS-1:0] x;
      logic [LEVEL_BITS-1:0] gap;
      logic [COEF_W-1:0]     coef;
      logic [PROD_W-1:0]     prod;
      x    = LEVEL_BITS'(val_ff);
      coef = (act_ff == ACT_PEAK) ? rel_ff : sm_ff;
      if (act_ff == ACT_PEAK) begin
         up_in = x > cur.peak;
         gap   = up_in ? '0 : cur.peak - x;
      end else begin
         up_in = x >= cur.avg;
         gap   = up_in ? x - cur.avg : cur.avg - x;
      end
      prod    = PROD_W'(coef) * PROD_W'(gap) + PROD_W'(HALF_Q16);
      step_in = prod[COEF_W +: LEVEL_BITS];
   end

   // channel update at write back
   always_comb begin
      logic [LEVEL_BITS-1:0] x;
      logic [OVERS_W:0]      sum;
      x   = LEVEL_BITS'(val_ff);
      sum = {1'b0, cur.overs} + {1'b0, val_ff};
      nxt = cur;
      case (act_ff)
         ACT_PEAK: begin
            nxt.peak = up_ff ? x : cur.peak - step_ff;
            if (nxt.peak > cur.hpeak) begin
               nxt.hpeak = nxt.peak;
            end
         end
         ACT_AVERAGE: begin
            nxt.avg = up_ff ? cur.avg + step_ff : cur.avg - step_ff;
            if (nxt.avg > cur.havg) begin
               nxt.havg = nxt.avg;
            end
         end
         ACT_ADD_OVERS: begin
            nxt.overs = sum[OVERS_W] ? OVER_MAX : sum[OVERS_W-1:0];
         end
         default: ;
      endcase
   end

   // sweep modification of one entry
   always_comb begin
      swp = cur;
      case (act_ff)
         ACT_CLEAR_OVERS: swp.overs = '0;
         ACT_RESET_MAX: begin
            swp.hpeak = cur.peak;
            swp.havg  = cur.avg;
         end
         default: ;
      endcase
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               idx_in = '0;
               if (is_sweep && (limit != '0)) begin
                  state_in = ST_SW_RD;
               end else if (is_sweep) begin
                  state_in = ST_RD;
               end else begin
                  state_in = ST_MUL;
               end
            end
         end
         ST_SW_RD: state_in = ST_SW_WR;
         ST_SW_WR: begin
            idx_in   = idx_ff + LIM_W'(1);
            state_in = (idx_in < limit) ? ST_SW_RD : ST_RD;
         end
         ST_RD:  state_in = ST_MUL;
         ST_MUL: state_in = ST_WB;
         ST_WB: begin
            if (wb_fire) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         if (wb_fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         act_ff      <= req.action;
         ch_ff       <= req.channel;
         val_ff      <= req.sample_value;
         ch_valid_ff <= LIM_W'(req.channel) < limit;
      end
      if (state_ff == ST_MUL) begin
         step_ff <= step_in;
         up_ff   <= up_in;
      end
      if (wb_fire) begin
         rsp_chv_ff   <= ch_valid_ff;
         rsp_peak_ff  <= ch_valid_ff ? VALUE_W'(nxt.peak) : '0;
         rsp_avg_ff   <= ch_valid_ff ? VALUE_W'(nxt.avg) : '0;
         rsp_hpeak_ff <= ch_valid_ff ? VALUE_W'(nxt.hpeak) : '0;
         rsp_havg_ff  <= ch_valid_ff ? VALUE_W'(nxt.havg) : '0;
         rsp_overs_ff <= ch_valid_ff ? nxt.overs : '0;
      end
   end

   mlm_chan_mem #(
      .DEPTH  (NUM_CHANNELS),
      .ADDR_W (CH_W),
      .DATA_W (ENTRY_W)
   ) u_mem (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data ((state_ff == ST_SW_WR) ? ENTRY_W'(swp) : ENTRY_W'(nxt))
   );

   assign rsp.valid           = rsp_valid_ff;
   assign rsp.channel_valid   = rsp_chv_ff;
   assign rsp.peak_out        = rsp_peak_ff;
   assign rsp.average_out     = rsp_avg_ff;
   assign rsp.max_peak_out    = rsp_hpeak_ff;
   assign rsp.max_average_out = rsp_havg_ff;
   assign rsp.overs_out       = rsp_overs_ff;

   `ASSERT_NEVER(a_no_wr_on_accept, wr_en && accept, "memory write while taking a request")
   `ASSERT_IMPLIES(a_wb_only_valid, wr_en && (state_ff == ST_WB), ch_valid_ff, "write to inactive channel")
   `ASSERT_IMPLIES(a_sweep_in_range, state_ff == ST_SW_RD, idx_ff < limit, "sweep index past active count")
   `ASSERT_IMPLIES(a_rsp_from_wb, $rose(rsp_valid_ff), $past(state_ff) == ST_WB, "response not from write back")

endmodule

/* rtl/mlm_chan_mem.sv */
// Channel state memory: one write and one registered read per cycle.
// Entries never written read as zero (per-entry valid bits cleared by reset).
module mlm_chan_mem #(
   parameter int DEPTH  = 8,
   parameter int ADDR_W = 3,
   parameter int DATA_W = 80
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DEPTH-1:0]  vld_ff;
   logic [DATA_W-1:0] rd_data_ff;
   logic              rd_vld_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff    <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            vld_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_vld_ff <= vld_ff[rd_addr];
         end
      end
   end

   assign rd_data = rd_vld_ff ? rd_data_ff : '0;

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
   import mlm_pkg::*;

   localparam int NCH          = 8;
   localparam int CYCLE_LIMIT  = 400000;
   // room for a clear-overs / reset-maxima walk over all channels; leave margin on top
   localparam int DRAIN_CYCLES = 2 * NCH + 12;

   // action codes the block treats as a plain read
   localparam logic [ACTION_W-1:0] ACT_SPARE_LO = 3'd6;
   localparam logic [ACTION_W-1:0] ACT_SPARE_HI = 3'd7;

   typedef struct packed {
      logic [ACTION_W-1:0]  action;
      logic [CHANNEL_W-1:0] channel;
      logic [VALUE_W-1:0]   sample_value;
   } meter_req_type;

   typedef struct packed {
      logic               channel_valid;
      logic [VALUE_W-1:0] peak;
      logic [VALUE_W-1:0] average;
      logic [VALUE_W-1:0] max_peak;
      logic [VALUE_W-1:0] max_average;
      logic [OVERS_W-1:0] overs;
   } meter_rsp_type;

   logic                  clock;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   mlm_req_if req_if ();
   mlm_rsp_if rsp_if ();

   multichannel_level_meter #(
      .NUM_CHANNELS (NCH),
      .LEVEL_BITS   (VALUE_W)
   ) uut (
      .clock     (clock),
      .reset     (reset),
      .req       (req_if),
      .rsp       (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // ---------------------------------------------------------------------
   // Shadow copy of the meter: per-channel table plus the three registers.
   // Registers only change while the block is idle, so the copy is updated
   // when the write is issued.
   // ---------------------------------------------------------------------
   logic [VALUE_W-1:0]  peak_lvl     [NCH];
   logic [VALUE_W-1:0]  avg_lvl      [NCH];
   logic [VALUE_W-1:0]  held_pk      [NCH];
   logic [VALUE_W-1:0]  held_avg     [NCH];
   logic [OVERS_W-1:0]  over_cnt     [NCH];
   logic [COEF_W-1:0]   rel_coef;
   logic [COEF_W-1:0]   smooth_coef;
   logic [ACTIVE_W-1:0] active_cfg;

   meter_req_type queued_actions[$];      // waiting for the driver
   meter_rsp_type predicted_readouts[$];  // waiting for the block's response

   int fail_count;
   int idle_pct;       // chance (percent) of starting an idle/stall burst
   int gap_left;
   int stall_left;
   int cycle_count;

   // Q0.16 coefficient times a gap, rounded half up.
   function automatic logic [VALUE_W-1:0] coef_scale(input logic [COEF_W-1:0] coef,
                                                     input logic [VALUE_W-1:0] gap);
      logic [32:0] prod;
      prod = 33'(coef) * 33'(gap) + 33'(HALF_Q16);
      return prod[31:16];
   endfunction

   // Applies one transaction to the shadow table and returns the readout.
   function automatic meter_rsp_type meter_step(input meter_req_type rq);
      meter_rsp_type      r;
      int                 lim;
      logic               live;
      logic [VALUE_W-1:0] lvl;
      logic [16:0]        sum;
      r   = '0;
      // counts above the table size saturate; zero leaves nothing active
      lim  = (active_cfg > NCH) ? NCH : int'(active_cfg);
      live = (rq.channel < lim);
      case (rq.action)
         ACT_PEAK: if (live) begin
            // instant attack, exponential release toward the input
            lvl = peak_lvl[rq.channel];
            if (rq.sample_value > lvl)
               lvl = rq.sample_value;
            else
               lvl = lvl - coef_scale(rel_coef, lvl - rq.sample_value);
            peak_lvl[rq.channel] = lvl;
            if (lvl > held_pk[rq.channel])
               held_pk[rq.channel] = lvl;
         end
         ACT_AVERAGE: if (live) begin
            lvl = avg_lvl[rq.channel];
            if (rq.sample_value >= lvl)
               lvl = lvl + coef_scale(smooth_coef, rq.sample_value - lvl);
            else
               lvl = lvl - coef_scale(smooth_coef, lvl - rq.sample_value);
            avg_lvl[rq.channel] = lvl;
            if (lvl > held_avg[rq.channel])
               held_avg[rq.channel] = lvl;
         end
         ACT_ADD_OVERS: if (live) begin
            sum = {1'b0, over_cnt[rq.channel]} + {1'b0, rq.sample_value};
            over_cnt[rq.channel] = sum[16] ? OVER_MAX : sum[15:0];
         end
         // global actions ignore the addressed channel
         ACT_CLEAR_OVERS: begin
            for (int c = 0; c < lim; c++)
               over_cnt[c] = '0;
         end
         ACT_RESET_MAX: begin
            for (int c = 0; c < lim; c++) begin
               held_pk[c]  = peak_lvl[c];
               held_avg[c] = avg_lvl[c];
            end
         end
         default: ;  // read and the spare codes change nothing
      endcase
      if (live) begin
         r.channel_valid = 1'b1;
         r.peak          = peak_lvl[rq.channel];
         r.average       = avg_lvl[rq.channel];
         r.max_peak      = held_pk[rq.channel];
         r.max_average   = held_avg[rq.channel];
         r.overs         = over_cnt[rq.channel];
      end
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // Clock and reset
   // ---------------------------------------------------------------------
   initial clock = 1'b0;
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Hard stop in case the block hangs.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t ns: timeout after %0d cycles", $time, cycle_count);
         $display("multichannel_level_meter verification failed");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Driver: presents queued transactions, with random idle bursts between
   // them. A new transaction is only loaded once the current one is taken.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
         gap_left = 0;
      end else if (!req_if.valid || req_if.ready) begin
         if (gap_left > 0) begin
            gap_left--;
            req_if.valid <= 1'b0;
         end else if (queued_actions.size() > 0 && idle_pct > 0 &&
                      $urandom_range(99) < idle_pct) begin
            // start an idle burst
            gap_left = $urandom_range(4);
            req_if.valid <= 1'b0;
         end else if (queued_actions.size() > 0) begin
            meter_req_type nxt;
            nxt = queued_actions.pop_front();
            req_if.valid        <= 1'b1;
            req_if.action       <= nxt.action;
            req_if.channel      <= nxt.channel;
            req_if.sample_value <= nxt.sample_value;
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // Field compare; every mismatch is reported and counted.
   task automatic check_field(input string name, input logic [15:0] want,
                              input logic [15:0] got);
      if (want !== got) begin
         $display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, want, got);
         fail_count++;
      end
   endtask

   // ---------------------------------------------------------------------
   // Monitor: checks the response side first, then predicts for any request
   // taken at this edge, so the result never depends on process order.
   // Also drives rsp ready with random stall bursts.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      meter_rsp_type want;
      meter_req_type seen;
      if (reset) begin
         rsp_if.ready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (predicted_readouts.size() == 0) begin
               $display("%0t ns: response with no transaction pending, actual %b %h %h %h %h %h",
                        $time, rsp_if.channel_valid, rsp_if.peak_out, rsp_if.average_out,
                        rsp_if.max_peak_out, rsp_if.max_average_out, rsp_if.overs_out);
               fail_count++;
            end else begin
               want = predicted_readouts.pop_front();
               check_field("channel_valid", 16'(want.channel_valid),
                           16'(rsp_if.channel_valid));
               check_field("peak_out", want.peak, rsp_if.peak_out);
               check_field("average_out", want.average, rsp_if.average_out);
               check_field("max_peak_out", want.max_peak, rsp_if.max_peak_out);
               check_field("max_average_out", want.max_average, rsp_if.max_average_out);
               check_field("overs_out", want.overs, rsp_if.overs_out);
            end
         end
         if (req_if.valid && req_if.ready) begin
            seen.action       = req_if.action;
            seen.channel      = req_if.channel;
            seen.sample_value = req_if.sample_value;
            predicted_readouts.push_back(meter_step(seen));
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_if.ready <= 1'b0;
         end else if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
            stall_left = $urandom_range(4);
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------
   task automatic queue_action(input logic [ACTION_W-1:0] act,
                               input logic [CHANNEL_W-1:0] ch,
                               input logic [VALUE_W-1:0] val);
      queued_actions.push_back('{act, ch, val});
   endtask

   // Mostly level updates, some overs, a few global actions and reads.
   function automatic meter_req_type random_action();
      meter_req_type it;
      int            pick;
      pick = $urandom_range(99);
      if (pick < 33)      it.action = ACT_PEAK;
      else if (pick < 66) it.action = ACT_AVERAGE;
      else if (pick < 78) it.action = ACT_ADD_OVERS;
      else if (pick < 81) it.action = ACT_CLEAR_OVERS;
      else if (pick < 84) it.action = ACT_RESET_MAX;
      else if (pick < 93) it.action = ACT_READ;
      else if (pick < 97) it.action = ACT_SPARE_LO;
      else                it.action = ACT_SPARE_HI;
      it.channel = CHANNEL_W'($urandom_range(NCH - 1));
      pick = $urandom_range(99);
      if (pick < 10)      it.sample_value = '0;
      else if (pick < 20) it.sample_value = 16'hFFFF;
      else if (pick < 35) it.sample_value = VALUE_W'($urandom_range(255));
      else                it.sample_value = VALUE_W'($urandom_range(16'hFFFF));
      return it;
   endfunction

   // All three registers, back to back; write enable stays high throughout.
   task automatic program_meter(input logic [COEF_W-1:0] rel,
                                input logic [COEF_W-1:0] sm,
                                input logic [CSR_DATA_W-1:0] active_word);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= CSR_PEAK_RELEASE;
      csr_wdata <= rel;
      @(posedge clock);
      csr_index <= CSR_AVERAGE_SMOOTH;
      csr_wdata <= sm;
      @(posedge clock);
      csr_index <= CSR_ACTIVE_CHANS;
      csr_wdata <= active_word;
      @(posedge clock);
      csr_we <= 1'b0;
      rel_coef    = rel;
      smooth_coef = sm;
      active_cfg  = active_word[ACTIVE_W-1:0];
   endtask

   // Waits until every queued transaction has been answered, then lets a
   // possible global walk finish.
   task automatic wait_drained();
      while (queued_actions.size() > 0 || req_if.valid || predicted_readouts.size() > 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic run_random(input int n_items, input int pct);
      idle_pct = pct;
      repeat (n_items) queued_actions.push_back(random_action());
      wait_drained();
   endtask

   // ---------------------------------------------------------------------
   // Test sequence
   // ---------------------------------------------------------------------
   initial begin
      reset               = 1'b1;
      cycle_count         = 0;
      fail_count          = 0;
      idle_pct            = 0;
      req_if.valid        = 1'b0;
      req_if.action       = '0;
      req_if.channel      = '0;
      req_if.sample_value = '0;
      rsp_if.ready        = 1'b0;
      csr_we              = 1'b0;
      csr_index           = '0;
      csr_wdata           = '0;
      for (int c = 0; c < NCH; c++) begin
         peak_lvl[c] = '0;
         avg_lvl[c]  = '0;
         held_pk[c]  = '0;
         held_avg[c] = '0;
         over_cnt[c] = '0;
      end
      rel_coef    = PEAK_RELEASE_RST;
      smooth_coef = AVERAGE_SMOOTH_RST;
      active_cfg  = ACTIVE_CHANS_RST;

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed pass on the reset register values.
      idle_pct = 30;
      queue_action(ACT_PEAK, 3'd0, 16'hFFFF);        // full-scale attack
      queue_action(ACT_PEAK, 3'd0, 16'h0000);        // release from the top
      queue_action(ACT_AVERAGE, 3'd0, 16'hFFFF);
      queue_action(ACT_AVERAGE, 3'd0, 16'h0000);     // average falls back
      queue_action(ACT_ADD_OVERS, 3'd0, 16'h0000);   // adding zero is a no-op
      queue_action(ACT_ADD_OVERS, 3'd0, 16'hFFFF);
      queue_action(ACT_ADD_OVERS, 3'd0, 16'h0001);   // saturates
      queue_action(ACT_READ, 3'd0, 16'h5A5A);
      queue_action(ACT_PEAK, 3'd7, 16'h8000);
      queue_action(ACT_AVERAGE, 3'd7, 16'h1234);
      queue_action(ACT_ADD_OVERS, 3'd7, 16'h0005);
      queue_action(ACT_CLEAR_OVERS, 3'd3, 16'hFFFF); // global, any channel
      queue_action(ACT_READ, 3'd0, 16'h0000);
      queue_action(ACT_READ, 3'd7, 16'h0000);
      queue_action(ACT_PEAK, 3'd0, 16'h0100);
      queue_action(ACT_RESET_MAX, 3'd5, 16'h0000);   // maxima drop to levels
      queue_action(ACT_READ, 3'd0, 16'h0000);
      queue_action(ACT_SPARE_LO, 3'd7, 16'hFFFF);
      queue_action(ACT_SPARE_HI, 3'd0, 16'hFFFF);
      queue_action(ACT_PEAK, 3'd1, 16'h0000);        // equal input, no move
      queue_action(ACT_AVERAGE, 3'd1, 16'h0000);
      queue_action(ACT_ADD_OVERS, 3'd2, 16'h7FFF);
      wait_drained();

      // Random phases across register extremes and active counts, including
      // zero (all channels ignored) and counts past the table size.
      program_meter(16'h0000, 16'h0000, 16'd8);
      run_random(150, 25);
      program_meter(16'hFFFF, 16'hFFFF, 16'd1);
      run_random(150, 40);
      program_meter(16'($urandom_range(16'hFFFF)), 16'($urandom_range(16'hFFFF)), 16'd0);
      run_random(60, 10);
      program_meter(16'($urandom_range(16'hFFFF)), 16'($urandom_range(16'hFFFF)),
                    {12'($urandom_range(12'hFFF)), 4'd15});
      run_random(150, 25);
      program_meter(16'($urandom_range(16'hFFFF)), 16'($urandom_range(16'hFFFF)), 16'd3);
      run_random(150, 0);
      program_meter(16'($urandom_range(16'hFFFF)), 16'($urandom_range(16'hFFFF)),
                    16'($urandom_range(NCH, 1)));
      run_random(150, 50);
      program_meter(16'($urandom_range(2000)), 16'($urandom_range(16'hFFFF)),
                    {12'($urandom_range(12'hFFF)), 4'd5});
      run_random(150, 25);
      // closing stretch at full rate, no idling on either side
      program_meter(16'($urandom_range(16'hFFFF)), 16'($urandom_range(16'hFFFF)), 16'd8);
      run_random(150, 0);

      if (fail_count == 0) begin
         $display("multichannel_level_meter verification clean");
      end else begin
         $display("multichannel_level_meter verification failed");
      end
      $finish;
   end

endmodule
